### rtl/rbw_pkg.sv
package rbw_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_MARK_EX  = 3'd1,
    OP_MARK_RDY = 3'd2,
    OP_WAKEUP   = 3'd3,
    OP_COMMIT   = 3'd4,
    OP_CHECK    = 3'd5
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_HEAD_BAD  = 3'd2;
  localparam logic [2:0] ST_NOT_VALID = 3'd3;
  localparam logic [2:0] ST_MARKED    = 3'd4;

  localparam logic [5:0] NONE_TAG = 6'h3f;
  localparam int unsigned TAG_SPAN = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMT,
    S_WAKE,
    S_FIN
  } state_t;

  // payload of one buffer entry as held in memory
  typedef struct packed {
    logic [31:0] inst_number;
    logic [5:0]  a_tag;
    logic        a_ready;
    logic [5:0]  b_tag;
    logic        b_ready;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  result_tag;
    logic        entry_is_ready;
    logic        head_can_commit;
    entry_t      entry;
  } res_t;

endpackage

### rtl/rbw_mem.sv
module rbw_mem import rbw_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rbw_ctrl.sv
module rbw_ctrl import rbw_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_clr,
  input  logic [5:0]    n_eff,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    op,
  input  logic [4:0]    tag,
  input  entry_t        in_entry,
  output logic          out_valid,
  input  logic          out_ready,
  output res_t          out_res,
  output logic          mem_we,
  output logic [IW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic          mem_re,
  output logic [IW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  localparam int CW = ((IW > 6) ? IW : 6) + 1;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     head_r, head_nxt, tail_r, tail_nxt, wk_r, wk_nxt;
  logic [5:0]        occ_r, occ_nxt;
  logic [4:0]        wtag_r, wtag_nxt;
  logic [DEPTH-1:0]  valid_r, valid_nxt, exec_r, exec_nxt, done_r, done_nxt;
  res_t              res_r, res_nxt, out_r, out_data;
  logic              out_valid_r, out_load;

  logic              slot_free, acc, tag_ok, tag_hit, cmt_ok, wk_last;
  logic [7:0]        tag8;
  logic [IW-1:0]     tidx;
  logic [CW-1:0]     n_w, head_w, tail_w, wk_w, occ_w;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign tag8      = {3'b000, tag};
  assign tidx      = tag8[IW-1:0];
  assign tag_ok    = {1'b0, tag} < n_eff;
  assign tag_hit   = tag_ok && valid_r[tidx];
  assign n_w       = CW'(n_eff);
  assign head_w    = CW'(head_r);
  assign tail_w    = CW'(tail_r);
  assign wk_w      = CW'(wk_r);
  assign occ_w     = CW'(occ_r);
  assign cmt_ok    = (head_w < n_w) && valid_r[head_r] && done_r[head_r];
  assign wk_last   = (wk_w + CW'(1)) >= n_w;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && op == OP_WAKEUP) begin
          state_nxt = S_WAKE;
        end else if (acc && op == OP_COMMIT && cmt_ok) begin
          state_nxt = S_CMT;
        end
      end
      S_CMT:  state_nxt = S_FIN;
      S_WAKE: begin
        if (wk_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_t          r;
    entry_t        e;
    logic          hit_a, hit_b;
    logic [CW-1:0] h1, t1;
    logic [IW-1:0] hn;
    r         = '0;
    e         = mem_rdata;
    hit_a     = 1'b0;
    hit_b     = 1'b0;
    h1        = head_w + CW'(1);
    t1        = tail_w + CW'(1);
    valid_nxt = valid_r;
    exec_nxt  = exec_r;
    done_nxt  = done_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    wk_nxt    = wk_r;
    wtag_nxt  = wtag_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = in_entry;
    mem_re    = 1'b0;
    mem_raddr = head_r;
    out_load  = 1'b0;
    out_data  = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority case (op)
            OP_INSERT: begin
              if (occ_w >= n_w || tail_w >= n_w) begin
                r.status = ST_FULL;
              end else begin
                mem_we           = 1'b1;
                valid_nxt[tail_r] = 1'b1;
                exec_nxt[tail_r]  = 1'b0;
                done_nxt[tail_r]  = 1'b0;
                tail_nxt         = (t1 >= n_w) ? '0 : t1[IW-1:0];
                occ_nxt          = occ_r + 6'd1;
                r.result_tag     = 5'(8'(tail_r));
              end
            end
            OP_MARK_EX: begin
              if (!tag_hit) r.status = ST_NOT_VALID;
              else if (exec_r[tidx]) r.status = ST_MARKED;
              else exec_nxt[tidx] = 1'b1;
            end
            OP_MARK_RDY: begin
              if (!tag_hit) r.status = ST_NOT_VALID;
              else if (done_r[tidx]) r.status = ST_MARKED;
              else done_nxt[tidx] = 1'b1;
            end
            OP_WAKEUP: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              wk_nxt    = '0;
              wtag_nxt  = tag;
            end
            OP_COMMIT: begin
              if (!cmt_ok) r.status = ST_HEAD_BAD;
              else mem_re = 1'b1;
            end
            OP_CHECK: begin
              if (!tag_hit) r.status = ST_NOT_VALID;
              else r.entry_is_ready = done_r[tidx];
            end
            default: ;
          endcase
        end
      end
      S_CMT: begin
        r.entry          = mem_rdata;
        r.result_tag     = 5'(8'(head_r));
        valid_nxt[head_r] = 1'b0;
        exec_nxt[head_r]  = 1'b0;
        done_nxt[head_r]  = 1'b0;
        head_nxt         = (h1 >= n_w) ? '0 : h1[IW-1:0];
        if (occ_r != 6'd0) occ_nxt = occ_r - 6'd1;
      end
      S_WAKE: begin
        // read of wk_r+1 overlaps the write back of wk_r: never the same entry
        if (valid_r[wk_r]) begin
          hit_a = (e.a_tag == {1'b0, wtag_r});
          hit_b = (e.b_tag == {1'b0, wtag_r});
        end
        if (hit_a) begin
          e.a_ready = 1'b1;
          e.a_tag   = NONE_TAG;
        end
        if (hit_b) begin
          e.b_ready = 1'b1;
          e.b_tag   = NONE_TAG;
        end
        mem_we    = hit_a || hit_b;
        mem_waddr = wk_r;
        mem_wdata = e;
        if (!wk_last) begin
          mem_re    = 1'b1;
          mem_raddr = wk_r + IW'(1);
          wk_nxt    = wk_r + IW'(1);
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_data = res_r;
        end
      end
      default: ;
    endcase

    hn = head_nxt;
    r.head_can_commit = (CW'(hn) < n_w) && valid_nxt[hn] && done_nxt[hn];

    if (state_r == S_IDLE && acc && state_nxt == S_IDLE) begin
      out_load = 1'b1;
      out_data = r;
    end
    if (state_r == S_CMT || (state_r == S_WAKE && wk_last)) begin
      res_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      valid_r     <= '0;
      exec_r      <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_clr) begin
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      valid_r <= '0;
      exec_r  <= '0;
      done_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      valid_r <= valid_nxt;
      exec_r  <= exec_nxt;
      done_r  <= done_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    wk_r   <= wk_nxt;
    wtag_r <= wtag_nxt;
    res_r  <= res_nxt;
    if (out_load) out_r <= out_data;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

### rtl/reorder_buffer_with_wakeup.sv
// Circular reorder buffer with operand wakeup. Each input item carries one operation
// (insert, mark executing, mark ready, wakeup, commit head, check ready) and yields one
// result item. Entry flags sit in flip-flops; the entry payload sits in a one-port-write,
// one-port-read memory with a registered read. Insert, mark, check and a refused commit
// load their result when taken; a commit reads the memory, updates and then gives the
// result; a wakeup sweeps the memory one entry per cycle (first read, then a compare and
// write back on a match for each of the N entries, then the result), N being the effective
// size. A result waits in an output register, and a new item is taken in the cycle it leaves.
// Writing entries_in_use (address 0) empties the buffer.
module reorder_buffer_with_wakeup import rbw_pkg::*; #(
  parameter int ROB_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tag[4:0], inst_number[36:5], first_source_tag[42:37], first_source_ready[43],
  // second_source_tag[49:44], second_source_ready[50]
  input  logic [55:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_tag[4:0], entry_is_ready[5], head_can_commit[6], out_inst_number[38:7],
  // out_first_source_tag[44:39], out_first_source_ready[45],
  // out_second_source_tag[51:46], out_second_source_ready[52]
  output logic [55:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW  = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int LIM = (ROB_DEPTH < TAG_SPAN) ? ROB_DEPTH : TAG_SPAN;

  logic [5:0]    eiu_r;
  logic [5:0]    n_eff;
  logic          cfg_wr;
  entry_t        in_entry, mem_wdata, mem_rdata;
  res_t          res;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {26'd0, eiu_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r <= 6'd32;
    end else if (cfg_wr) begin
      eiu_r <= cfg_pwdata[5:0];
    end
  end

  // zero acts as one, anything past the usable span is clamped
  always_comb begin
    if (eiu_r == 6'd0) n_eff = 6'd1;
    else if (eiu_r > 6'(LIM)) n_eff = 6'(LIM);
    else n_eff = eiu_r;
  end

  assign in_entry.inst_number = in_tdata[36:5];
  assign in_entry.a_tag       = in_tdata[42:37];
  assign in_entry.a_ready     = in_tdata[43];
  assign in_entry.b_tag       = in_tdata[49:44];
  assign in_entry.b_ready     = in_tdata[50];

  rbw_mem #(.DEPTH(ROB_DEPTH), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rbw_ctrl #(.DEPTH(ROB_DEPTH), .IW(IW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clr   (cfg_wr),
    .n_eff     (n_eff),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op        (in_tuser),
    .tag       (in_tdata[4:0]),
    .in_entry  (in_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign out_tuser = res.status;
  assign out_tdata = {3'b000, res.entry.b_ready, res.entry.b_tag, res.entry.a_ready,
                      res.entry.a_tag, res.entry.inst_number, res.head_can_commit,
                      res.entry_is_ready, res.result_tag};

  a_take_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("item taken while the output register is blocked");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_FULL || out_tuser == ST_HEAD_BAD
                    || out_tuser == ST_NOT_VALID || out_tuser == ST_MARKED))
    else $error("unknown status");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[5:0] == 6'd0
                                            && out_tdata[52:7] == 46'd0))
    else $error("error result carries payload");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (eiu_r == $past(cfg_pwdata[5:0])))
    else $error("register write lost");

endmodule
